[hw/rtl/montgomery_modular_exponentiation_top_defines.svh]
// Assertion macros shared by the modular exponentiation RTL.
// No dependencies.
`ifndef MONTGOMERY_MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MONTGOMERY_MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("fail");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[hw/rtl/mme_pkg.sv]
// Types and constants for the modular exponentiation block.
// No dependencies.
package mme_pkg;
  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  word_index;
    logic [31:0] word_data;
    logic        start_last;
  } mme_in_t;

  typedef struct packed {
    logic [1:0]  result_index;
    logic [31:0] result_word;
    logic        result_last;
  } mme_out_t;

  localparam logic [1:0] REQ_MOD = 2'd0;
  localparam logic [1:0] REQ_RSQ = 2'd1;
  localparam logic [1:0] REQ_EXP = 2'd2;
  localparam logic [1:0] REQ_BASE = 2'd3;
endpackage

[hw/rtl/mme_mont_unit.sv]
// Bit-serial Montgomery product over a word memory of partial and operand.
// Depends on mme_pkg and the defines header.
`include "montgomery_modular_exponentiation_top_defines.svh"
module mme_mont_unit #(
  parameter int NUM_WORDS = 5,
  parameter int WORD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic [7:0]                       rounds,
  input  logic [NUM_WORDS*WORD_BITS-1:0]   a,
  input  logic [NUM_WORDS*WORD_BITS-1:0]   b,
  input  logic [NUM_WORDS*WORD_BITS-1:0]   n,
  output logic                             done,
  output logic [NUM_WORDS*WORD_BITS-1:0]   p
);
  import mme_pkg::*;
  localparam int W = NUM_WORDS * WORD_BITS;
  localparam int IW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  typedef enum logic [1:0] {S_IDLE = 2'b01, S_RUN = 2'b10} st_t;
  st_t st;
  logic [7:0] cnt;
  // word-wise storage: partial sum and shifted operand, read and written per word
  logic [WORD_BITS-1:0] pmem [NUM_WORDS];
  logic [WORD_BITS-1:0] amem [NUM_WORDS];
  logic [IW-1:0] widx;
  // partial plus b plus n can carry two into the next word
  logic [1:0] carry;
  logic addb, addn;
  logic [WORD_BITS-1:0] plo, alo, nxt_top;
  logic [WORD_BITS+1:0] wsum;
  logic [WORD_BITS-1:0] pw, aw, bw, nw;
  logic                 phase; // 0 add pass, 1 shift pass
  logic [WORD_BITS-1:0] pprev, aprev;

  always_comb begin
    pw = pmem[widx];
    aw = amem[widx];
    bw = b[widx*WORD_BITS +: WORD_BITS];
    nw = n[widx*WORD_BITS +: WORD_BITS];
    wsum = {2'b0, pw} + (addb ? {2'b0, bw} : '0) + (addn ? {2'b0, nw} : '0)
      + {{WORD_BITS{1'b0}}, carry};
    plo = pw; alo = aw; nxt_top = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      done <= 1'b0;
      cnt <= '0;
      widx <= '0;
      phase <= 1'b0;
      carry <= 2'b0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: if (go) begin
          for (int i = 0; i < NUM_WORDS; i++) begin
            pmem[i] <= '0;
            amem[i] <= a[i*WORD_BITS +: WORD_BITS];
          end
          cnt <= '0; widx <= '0; phase <= 1'b0; carry <= 2'b0;
          addb <= a[0];
          addn <= a[0] & b[0];
          if (rounds == 8'd0) begin
            done <= 1'b1;
            for (int i = 0; i < NUM_WORDS; i++) p[i*WORD_BITS +: WORD_BITS] <= '0;
          end else st <= S_RUN;
        end
        S_RUN: begin
          if (!phase) begin
            pmem[widx] <= wsum[WORD_BITS-1:0];
            carry <= wsum[WORD_BITS+1:WORD_BITS];
            if (widx == IW'(NUM_WORDS-1)) begin
              widx <= '0; phase <= 1'b1;
            end else widx <= widx + 1'b1;
          end else begin
            // shift right by one, low word first, using the next word's low bit
            if (widx == IW'(NUM_WORDS-1)) begin
              pmem[widx] <= pw >> 1;
              amem[widx] <= aw >> 1;
              widx <= '0; phase <= 1'b0; carry <= 2'b0;
              cnt <= cnt + 1'b1;
              if (cnt + 8'd1 == rounds) begin
                st <= S_IDLE; done <= 1'b1;
                for (int i = 0; i < NUM_WORDS - 1; i++)
                  p[i*WORD_BITS +: WORD_BITS] <= pmem[i];
                p[W-1 -: WORD_BITS] <= pw >> 1;
              end else begin
                addb <= amem[0][0];
                addn <= pmem[0][0] ^ (amem[0][0] & b[0]);
              end
            end else begin
              pmem[widx] <= {pmem[widx+1'b1][0], pw[WORD_BITS-1:1]};
              amem[widx] <= {amem[widx+1'b1][0], aw[WORD_BITS-1:1]};
              if (widx == '0) begin
                addb <= aw[1];
                addn <= pw[1] ^ (aw[1] & b[0]);
              end
              widx <= widx + 1'b1;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^{plo, alo, nxt_top, pprev, aprev};
  assign pprev = '0;
  assign aprev = '0;

  `ASSERT_IMPLIES(a_run_not_go, clk, rst, st == S_RUN, !done)
  `ASSERT_NEXT(a_done_idle, clk, rst, done, st == S_IDLE)
  `ASSERT_IMPLIES(a_cnt_bound, clk, rst, st == S_RUN, cnt < rounds)
endmodule

[hw/rtl/montgomery_modular_exponentiation_top.sv]
// Top level: operand load, exponentiation sequencer, result words.
// Depends on mme_pkg, mme_mont_unit and the defines header.
//
// Channel | Handshake        | Payload
// in      | start / busy     | in_item (mme_in_t)
// cfg     | cfg_valid/ready  | cfg_data (exp_bits)
// out     | out_valid strobe | out_item (mme_out_t)
//
// A start beat runs up to 2*exp_bits+3 products (a multiply is skipped for each
// clear exponent bit). Each product takes exp_bits rounds of an add pass and a
// shift pass over the words; after the last product, NUM_WORDS-1 result words
// leave on consecutive cycles.
// Reset is synchronous and sets exp_bits to 128. The receiver cannot stall.
`include "montgomery_modular_exponentiation_top_defines.svh"
module montgomery_modular_exponentiation_top #(
  parameter int NUM_WORDS = 5,
  parameter int WORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mme_pkg::mme_in_t in_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data,
  output logic             out_valid,
  output mme_pkg::mme_out_t out_item
);
  import mme_pkg::*;
  localparam int W = NUM_WORDS * WORD_BITS;
  localparam int DW = NUM_WORDS - 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int XW = $clog2(DW);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_K1 = 6'b000010, S_KM = 6'b000100,
    S_LOOP = 6'b001000, S_OUT1 = 6'b010000, S_EMIT = 6'b100000
  } st_t;
  st_t st;
  logic [7:0] exp_bits;
  logic [WORD_BITS-1:0] nst [DW];
  logic [WORD_BITS-1:0] kst [DW];
  logic [WORD_BITS-1:0] est [DW];
  logic [WORD_BITS-1:0] mst [DW];
  logic [W-1:0] prod, sq, n, k, m, one, ma, mb;
  logic [W-1:0] mp;
  logic go, mdone, waiting, sq_phase;
  logic [7:0] i;
  logic [7:0] inext;
  logic [2:0] oi;
  logic ebit;

  assign busy = (st != S_IDLE);
  assign cfg_ready = (st == S_IDLE);

  always_comb begin
    n = '0; k = '0; m = '0; one = '0; one[0] = 1'b1;
    for (int j = 0; j < DW; j++) begin
      n[j*WORD_BITS +: WORD_BITS] = nst[j];
      k[j*WORD_BITS +: WORD_BITS] = kst[j];
      m[j*WORD_BITS +: WORD_BITS] = mst[j];
    end
    // exponent bit for the next round; bits past the stored words read as zero
    inext = i + 8'd1;
    ebit = 1'b0;
    if (32'(inext) < 32'(DW*WORD_BITS)) ebit = est[inext[BW +: XW]][inext[BW-1:0]];
  end

  mme_mont_unit #(.NUM_WORDS(NUM_WORDS), .WORD_BITS(WORD_BITS)) u_mont (
    .clk(clk), .rst(rst), .go(go), .rounds(exp_bits),
    .a(ma), .b(mb), .n(n), .done(mdone), .p(mp));

  always_ff @(posedge clk) begin
    if (start && !busy && {1'b0, in_item.word_index} < 3'(DW)) begin
      case (in_item.req_type)
        REQ_MOD: nst[in_item.word_index] <= in_item.word_data[WORD_BITS-1:0];
        REQ_RSQ: kst[in_item.word_index] <= in_item.word_data[WORD_BITS-1:0];
        REQ_EXP: est[in_item.word_index] <= in_item.word_data[WORD_BITS-1:0];
        default: mst[in_item.word_index] <= in_item.word_data[WORD_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; exp_bits <= 8'd128; go <= 1'b0; waiting <= 1'b0;
      out_valid <= 1'b0; i <= '0; oi <= '0; sq_phase <= 1'b0;
      prod <= '0; sq <= '0;
    end else begin
      go <= 1'b0; out_valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (cfg_valid) exp_bits <= cfg_data;
          if (start && in_item.req_type == REQ_BASE && in_item.start_last) begin
            st <= S_K1; ma <= k; mb <= one; go <= 1'b1; waiting <= 1'b1;
          end
        end
        S_K1: if (mdone && !go) begin
          prod <= mp; st <= S_KM; ma <= k; go <= 1'b1;
          mb <= m;
        end
        S_KM: if (mdone && !go) begin
          sq <= mp; i <= '0;
          if (exp_bits == 8'd0) begin
            st <= S_OUT1; ma <= prod; mb <= one; go <= 1'b1; sq_phase <= 1'b0;
          end else begin
            st <= S_LOOP; go <= 1'b1; mb <= mp;
            // multiply step skipped when the bit is clear
            if (est[0][0]) begin
              ma <= prod; sq_phase <= 1'b0;
            end else begin
              ma <= mp; sq_phase <= 1'b1;
            end
          end
        end
        S_LOOP: if (mdone && !go) begin
          if (!sq_phase) begin
            prod <= mp; sq_phase <= 1'b1; ma <= sq; mb <= sq; go <= 1'b1;
          end else begin
            sq <= mp;
            if (i + 8'd1 == exp_bits) begin
              st <= S_OUT1; ma <= prod; mb <= one; go <= 1'b1;
            end else begin
              i <= i + 8'd1; st <= S_LOOP; go <= 1'b1; mb <= mp;
              if (ebit) begin
                sq_phase <= 1'b0; ma <= prod;
              end else begin
                sq_phase <= 1'b1; ma <= mp;
              end
            end
          end
        end
        S_OUT1: if (mdone && !go) begin
          prod <= mp; st <= S_EMIT; oi <= '0;
        end
        S_EMIT: begin
          out_valid <= 1'b1;
          out_item.result_index <= oi[1:0];
          out_item.result_word <= 32'(prod[oi*WORD_BITS +: WORD_BITS]);
          out_item.result_last <= (oi == 3'(DW-1));
          if (oi == 3'(DW-1)) st <= S_IDLE;
          oi <= oi + 1'b1;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^{waiting};

  `ASSERT_IMPLIES(a_cfg_idle, clk, rst, cfg_ready, !busy)
  `ASSERT_NEXT(a_emit_last_idle, clk, rst, st == S_EMIT && oi == 3'(DW-1), st == S_IDLE)
  `ASSERT_IMPLIES(a_out_busy, clk, rst, out_valid && !out_item.result_last, busy)
endmodule

[verif/montgomery_modular_exponentiation_top_test.sv]
// Self-checking bench for the Montgomery modular exponentiation block.
// Depends on mme_pkg and montgomery_modular_exponentiation_top.
// Loads operand words, runs base^exponent mod modulus and checks result words.
module montgomery_modular_exponentiation_top_test;
  import mme_pkg::*;

  typedef bit [159:0] wide_t;

  localparam int IDLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 40;

  class mme_scoreboard;
    bit [7:0]  exp_bits = 8'd128;
    bit [31:0] mod_w[4];
    bit [31:0] rsq_w[4];
    bit [31:0] exp_w[4];
    bit [31:0] base_w[4];
    mme_out_t  pending_words[$];
    int        errors;

    function wide_t mont_product(wide_t a, wide_t b, wide_t n);
      wide_t p;
      wide_t s;
      bit    q;
      p = '0;
      s = a;
      for (int r = 0; r < exp_bits; r++) begin
        q = p[0] ^ (s[0] & b[0]);
        if (s[0]) p = p + b;
        if (q) p = p + n;
        p = p >> 1;
        s = s >> 1;
      end
      return p;
    endfunction

    function wide_t modexp();
      wide_t n;
      wide_t k;
      wide_t e;
      wide_t m;
      wide_t one;
      wide_t prod;
      wide_t sq;
      n = {32'd0, mod_w[3], mod_w[2], mod_w[1], mod_w[0]};
      k = {32'd0, rsq_w[3], rsq_w[2], rsq_w[1], rsq_w[0]};
      e = {32'd0, exp_w[3], exp_w[2], exp_w[1], exp_w[0]};
      m = {32'd0, base_w[3], base_w[2], base_w[1], base_w[0]};
      one = 160'd1;
      prod = mont_product(k, one, n);
      sq = mont_product(k, m, n);
      for (int i = 0; i < exp_bits; i++) begin
        if (i < 160 && e[i]) prod = mont_product(prod, sq, n);
        sq = mont_product(sq, sq, n);
      end
      return mont_product(prod, one, n);
    endfunction

    function void note_load(mme_in_t x);
      wide_t    r;
      mme_out_t w;
      case (x.req_type)
        REQ_MOD:  mod_w[x.word_index] = x.word_data;
        REQ_RSQ:  rsq_w[x.word_index] = x.word_data;
        REQ_EXP:  exp_w[x.word_index] = x.word_data;
        default:  base_w[x.word_index] = x.word_data;
      endcase
      if (x.req_type == REQ_BASE && x.start_last) begin
        r = modexp();
        for (int i = 0; i < 4; i++) begin
          w.result_index = i[1:0];
          w.result_word = r[32*i +: 32];
          w.result_last = (i == 3);
          pending_words.push_back(w);
        end
      end
    endfunction

    function void check_word(mme_out_t y);
      mme_out_t w;
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", y);
        return;
      end
      w = pending_words.pop_front();
      if (y.result_index !== w.result_index || y.result_word !== w.result_word ||
          y.result_last !== w.result_last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected idx %0d word %h last %0b, got idx %0d word %h last %0b",
                   w.result_index, w.result_word, w.result_last,
                   y.result_index, y.result_word, y.result_last);
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  mme_in_t  in_item = '0;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [7:0] cfg_data = 8'd0;
  logic     out_valid;
  mme_out_t out_item;

  mme_scoreboard sb = new();
  int idle_cycles = 0;

  montgomery_modular_exponentiation_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid) sb.check_word(out_item);
  end

  // Restart the count on any accepted beat on any channel.
  always @(posedge clk) begin
    if (rst || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one load beat; keep start high if the next beat follows at once.
  task automatic send_word(logic [1:0] t, logic [1:0] idx, logic [31:0] d, logic last);
    int gap;
    in_item <= '{req_type: t, word_index: idx, word_data: d, start_last: last};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_load('{req_type: t, word_index: idx, word_data: d, start_last: last});
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_exp_bits(logic [7:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.exp_bits = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_all(logic [31:0] fill, logic odd_mod);
    for (int i = 0; i < 4; i++) begin
      send_word(REQ_MOD, i[1:0], (fill ^ $urandom()) | {31'd0, odd_mod}, 1'b0);
      send_word(REQ_RSQ, i[1:0], fill ^ $urandom(), 1'b0);
      send_word(REQ_EXP, i[1:0], fill ^ $urandom(), 1'b0);
      send_word(REQ_BASE, i[1:0], fill ^ $urandom(), i == 3);
    end
  endtask

  initial begin
    logic [1:0] t;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme words, a start on a non-base word, zero and one rounds.
    write_exp_bits(8'd8);
    send_word(REQ_MOD, 2'd0, 32'hFFFF_FFFF, 1'b0);
    send_word(REQ_MOD, 2'd1, 32'h0000_0000, 1'b0);
    send_word(REQ_MOD, 2'd2, 32'hFFFF_FFFF, 1'b0);
    send_word(REQ_MOD, 2'd3, 32'h0000_0000, 1'b0);
    for (int i = 0; i < 4; i++) begin
      send_word(REQ_RSQ, i[1:0], 32'hFFFF_FFFF, 1'b1);
      send_word(REQ_EXP, i[1:0], 32'hFFFF_FFFF, 1'b1);
      send_word(REQ_BASE, i[1:0], 32'h0000_0000, 1'b0);
    end
    send_word(REQ_BASE, 2'd0, 32'h0000_0003, 1'b1);
    wait_results();
    write_exp_bits(8'd0);
    send_word(REQ_BASE, 2'd3, 32'hFFFF_FFFF, 1'b1);
    wait_results();
    write_exp_bits(8'd1);
    send_word(REQ_EXP, 2'd0, 32'h0000_0001, 1'b0);
    send_word(REQ_BASE, 2'd1, 32'h8000_0001, 1'b1);
    wait_results();
    write_exp_bits(8'd128);
    load_all(32'hFFFF_FFFF, 1'b1);
    wait_results();

    // Random phases: full reloads with short updates and starts between them.
    for (int ph = 0; ph < 3; ph++) begin
      write_exp_bits(8'($urandom_range(1, 20)));
      load_all($urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF, $urandom_range(0, 3) != 0);
      repeat (6) begin
        t = 2'($urandom_range(0, 3));
        send_word(t, 2'($urandom_range(0, 3)), $urandom(),
                  (t == REQ_BASE) ? ($urandom_range(0, 2) != 0) : 1'($urandom_range(0, 1)));
      end
      send_word(REQ_BASE, 2'($urandom_range(0, 3)), $urandom(), 1'b1);
      wait_results();
    end

    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/mme_pkg.sv
hw/rtl/mme_mont_unit.sv
hw/rtl/montgomery_modular_exponentiation_top.sv
verif/montgomery_modular_exponentiation_top_test.sv
